// ===== rtl/rlqa_pkg.sv =====
package rlqa_pkg;

  // Field widths
  localparam int OP_W       = 3;
  localparam int ID_W       = 16;
  localparam int TIME_W     = 32;
  localparam int EST_W      = 16;
  localparam int NODES_W    = 10;
  localparam int ACT_W      = 10;
  localparam int QCNT_W     = 7;
  localparam int KIND_W     = 2;
  localparam int RATE_W     = 20;
  localparam int BURST_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Stream bus widths (fields packed from bit 0, padded to whole bytes)
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 40;

  // Rate is Q12.8 per second
  localparam int RATE_FRAC_BITS = 8;
  // Credit cap in whole queries: burst + nodes - 1 fits 17 bits
  localparam int CAPQ_W = 17;
  // Estimated total grows by up to MAX_RESULTS node counts per check
  localparam int EST_SUM_W = 17;

  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = 6;
  localparam logic [ACT_W-1:0] ACTIVE_MAX = 10'd1023;

  localparam int DEF_QUEUE_DEPTH    = 32;
  localparam int DEF_TIME_FRAC_BITS = 10;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE  = 3'd0;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd1;
  localparam logic [OP_W-1:0] OP_CHECK    = 3'd2;
  localparam logic [OP_W-1:0] OP_ABORT    = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT    = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRAIN_RATE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAIN_BURST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OWN_ACTIVE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OWN_ACTIVE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOTAL_ACTIVE = 3'd4;

  // Wait queue control
  typedef struct packed {
    logic push;
    logic pop;
  } rlqa_qctl_t;

endpackage

// ===== rtl/rate_limited_query_admission_unit.sv =====
// Sequencing: an accepted enqueue or active-count bump finishes in the idle state and yields no
//   result; a rejected enqueue goes straight to the drain state, an abort pops ids there, and a
//   check or complete first passes the time, multiply and credit stages, then one queue pop.
// Each result moves from the pending register to the output stage; up to 32 per item. Input is
//   ready only in the idle state, so a new item waits for the last one and any result stalls.
// Reset: synchronous, active high; clears pointers, counts, credit, stamp, cfg (ceiling max).
module rate_limited_query_admission_unit
  import rlqa_pkg::*;
#(
  parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
  parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [2:0] op, [18:3] query_id, [50:19] now_time, [66:51] estimated_active,
  // [76:67] dispatch_nodes, [79:77] zero
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] query_id_res, [25:16] active_count, [32:26] queue_count, [39:33] zero
  output logic [M_TDATA_W-1:0]  m_tdata,
  // [1:0] kind
  output logic [KIND_W-1:0]     m_tuser,
  output logic                  m_tlast,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int DELAY_W  = TIME_FRAC_BITS + 2;
  localparam int PROD_W   = DELAY_W + RATE_W;
  localparam int CREDIT_W = CAPQ_W + TIME_FRAC_BITS;
  localparam int UNIT_W   = NODES_W + TIME_FRAC_BITS;
  localparam logic [TIME_W-1:0] TWO_SEC = TIME_W'(2) << TIME_FRAC_BITS;

  typedef enum logic [2:0] {ST_IDLE, ST_TIME, ST_MUL, ST_CRED, ST_DRAIN} state_t;
  typedef enum logic [1:0] {MODE_CHECK, MODE_ABORT, MODE_REJECT} mode_t;

  state_t state;
  mode_t  mode;

  // Configuration registers
  logic [RATE_W-1:0]  drain_rate;
  logic [BURST_W-1:0] drain_burst;
  logic [ACT_W-1:0]   min_own_active;
  logic [ACT_W-1:0]   max_own_active;
  logic [EST_W-1:0]   min_total_active;

  // Block state outside the queue memory
  logic [ACT_W-1:0]    own_active;
  logic [CREDIT_W-1:0] drain_credit;
  logic [TIME_W-1:0]   drain_stamp;
  logic                abort_latched;

  // Per-item working registers
  logic [TIME_W-1:0]    now_r;
  logic [EST_SUM_W-1:0] est_r;
  logic [NODES_W-1:0]   nodes_r;
  logic [DELAY_W-1:0]   delay;
  logic [PROD_W-1:0]    prod;
  logic [RES_CNT_W-1:0] n_res;

  // Pending result, one step behind the pop so its last flag is known
  logic              have_pend;
  logic [ID_W-1:0]   pend_id;
  logic [KIND_W-1:0] pend_kind;
  logic [ACT_W-1:0]  pend_active;
  logic [CNT_W-1:0]  pend_queue;

  // Output stage
  logic [ID_W-1:0]   out_id;
  logic [ACT_W-1:0]  out_active;
  logic [QCNT_W-1:0] out_queue;

  // Input fields
  logic [OP_W-1:0]    in_op;
  logic [ID_W-1:0]    in_id;
  logic [TIME_W-1:0]  in_now;
  logic [EST_W-1:0]   in_est;
  logic [NODES_W-1:0] in_nodes;

  assign in_op    = s_tdata[2:0];
  assign in_id    = s_tdata[18:3];
  assign in_now   = s_tdata[50:19];
  assign in_est   = s_tdata[66:51];
  assign in_nodes = s_tdata[76:67];

  // Queue
  rlqa_qctl_t       qctl;
  logic [ID_W-1:0]  q_head;
  logic [CNT_W-1:0] q_count;
  logic             q_full;

  rlqa_wait_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (qctl),
    .push_data (in_id),
    .head_data (q_head),
    .count     (q_count)
  );

  logic               s_acc;
  logic               out_free;
  logic               out_load;
  logic [ACT_W-1:0]   min_own;
  logic [UNIT_W-1:0]  unit;
  logic               credit_ok;
  logic               check_ok;
  logic               more;
  logic               can_step;
  logic [TIME_W-1:0]  diff;
  logic [CAPQ_W-1:0]  cap_q;
  logic [CREDIT_W-1:0] cap;
  logic [CREDIT_W:0]  credit_sum;

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign q_full   = (q_count == CNT_W'(QUEUE_DEPTH));

  // After an abort the own minimum counts as zero for good
  assign min_own   = abort_latched ? '0 : min_own_active;
  assign unit      = {nodes_r, {TIME_FRAC_BITS{1'b0}}};
  assign credit_ok = (drain_credit >= CREDIT_W'(unit));
  assign diff      = now_r - drain_stamp;

  // Cap the credit at burst plus nodes minus one whole queries
  assign cap_q      = CAPQ_W'(drain_burst) + CAPQ_W'(nodes_r) - 1'b1;
  assign cap        = {cap_q, {TIME_FRAC_BITS{1'b0}}};
  assign credit_sum = (CREDIT_W + 1)'(drain_credit) + (CREDIT_W + 1)'(prod[PROD_W-1:RATE_FRAC_BITS]);

  // Release one id while credit or the own minimum allows, within the ceilings; abort pops any id
  always_comb begin
    check_ok = (credit_ok || (own_active < min_own))
            && (q_count != '0)
            && (own_active < max_own_active)
            && !((own_active >= min_own) && (est_r >= EST_SUM_W'(min_total_active)));
    more = 1'b0;
    if (n_res < RES_CNT_W'(MAX_RESULTS)) begin
      case (mode)
        MODE_CHECK: more = check_ok;
        MODE_ABORT: more = (q_count != '0);
        default:    more = 1'b0;
      endcase
    end
  end

  // Pending result must leave before the next one is taken
  assign can_step = !have_pend || out_free;
  assign out_load = (state == ST_DRAIN) && can_step && have_pend;

  always_comb begin
    qctl.push = s_acc && (in_op == OP_ENQUEUE) && !q_full;
    qctl.pop  = (state == ST_DRAIN) && can_step && more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      mode             <= MODE_CHECK;
      m_tvalid         <= 1'b0;
      have_pend        <= 1'b0;
      own_active       <= '0;
      drain_credit     <= '0;
      drain_stamp      <= '0;
      abort_latched    <= 1'b0;
      n_res            <= '0;
      drain_rate       <= '0;
      drain_burst      <= '0;
      min_own_active   <= '0;
      max_own_active   <= ACTIVE_MAX;
      min_total_active <= '0;
    end else begin
      // Configuration writes; indexes beyond the list are dropped
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DRAIN_RATE:       drain_rate       <= cfg_data[RATE_W-1:0];
          REG_DRAIN_BURST:      drain_burst      <= cfg_data[BURST_W-1:0];
          REG_MIN_OWN_ACTIVE:   min_own_active   <= cfg_data[ACT_W-1:0];
          REG_MAX_OWN_ACTIVE:   max_own_active   <= cfg_data[ACT_W-1:0];
          REG_MIN_TOTAL_ACTIVE: min_total_active <= cfg_data[EST_W-1:0];
          default: ;
        endcase
      end

      // Load the output stage from the pending result, or free it once its
      // transaction completes
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            now_r   <= in_now;
            est_r   <= EST_SUM_W'(in_est);
            nodes_r <= (in_nodes == '0) ? NODES_W'(1) : in_nodes;
            n_res   <= '0;
            mode    <= MODE_CHECK;
            unique case (in_op)
              OP_ENQUEUE: begin
                // Full queue: hand the id back as rejected, state untouched
                if (q_full) begin
                  pend_id     <= in_id;
                  pend_kind   <= KIND_REJECT;
                  pend_active <= own_active;
                  pend_queue  <= q_count;
                  have_pend   <= 1'b1;
                  mode        <= MODE_REJECT;
                  state       <= ST_DRAIN;
                end
              end
              OP_COMPLETE: begin
                if (own_active != '0) begin
                  own_active <= own_active - 1'b1;
                end
                state <= ST_TIME;
              end
              OP_CHECK: begin
                state <= ST_TIME;
              end
              OP_ABORT: begin
                abort_latched <= 1'b1;
                mode          <= MODE_ABORT;
                state         <= ST_DRAIN;
              end
              OP_COUNT: begin
                if (own_active < ACTIVE_MAX) begin
                  own_active <= own_active + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end

        ST_TIME: begin
          // Elapsed time, clamped to 2 s with stamp catch-up; time going back adds nothing
          if (now_r >= drain_stamp) begin
            if (diff > TWO_SEC) begin
              delay       <= TWO_SEC[DELAY_W-1:0];
              drain_stamp <= (drain_stamp == '0) ? now_r : drain_stamp + TWO_SEC;
            end else begin
              delay       <= diff[DELAY_W-1:0];
              drain_stamp <= now_r;
            end
          end else begin
            delay <= '0;
          end
          state <= ST_MUL;
        end

        ST_MUL: begin
          prod  <= PROD_W'(delay) * PROD_W'(drain_rate);
          state <= ST_CRED;
        end

        ST_CRED: begin
          drain_credit <= (credit_sum >= (CREDIT_W + 1)'(cap)) ? cap
                                                               : credit_sum[CREDIT_W-1:0];
          state        <= ST_DRAIN;
        end

        ST_DRAIN: begin
          if (can_step) begin
            // Move the pending result out; it is last unless another pop follows
            if (have_pend) begin
              out_id     <= pend_id;
              m_tuser    <= pend_kind;
              out_active <= pend_active;
              out_queue  <= QCNT_W'(pend_queue);
              m_tlast    <= !more;
            end
            if (more) begin
              pend_id    <= q_head;
              pend_queue <= q_count - 1'b1;
              have_pend  <= 1'b1;
              n_res      <= n_res + 1'b1;
              if (mode == MODE_CHECK) begin
                pend_kind   <= KIND_RELEASE;
                pend_active <= own_active + 1'b1;
                own_active  <= own_active + 1'b1;
                est_r       <= est_r + EST_SUM_W'(nodes_r);
                drain_credit <= credit_ok ? drain_credit - CREDIT_W'(unit) : '0;
              end else begin
                pend_kind   <= KIND_ABORT;
                pend_active <= own_active;
              end
            end else begin
              have_pend <= 1'b0;
              state     <= ST_IDLE;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {(M_TDATA_W - ID_W - ACT_W - QCNT_W)'(0), out_queue, out_active, out_id};

endmodule

// ===== rtl/rlqa_wait_queue.sv =====
module rlqa_wait_queue
  import rlqa_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int PTR_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  rlqa_qctl_t       ctl,
  input  logic [ID_W-1:0]  push_data,
  output logic [ID_W-1:0]  head_data,
  output logic [CNT_W-1:0] count
);

  logic [ID_W-1:0]  mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_next;

  always_comb begin
    head_next = head;
    if (ctl.pop) begin
      head_next = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (ctl.push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      case ({ctl.push, ctl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage: one write port at the tail, registered read of the next head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= push_data;
    end
    head_data <= mem[head_next];
  end

endmodule

// ===== rtl/rlqa_checker.sv =====
module rlqa_checker
  import rlqa_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [KIND_W-1:0]    m_tuser,
  input logic                 m_tlast
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A rejected enqueue is a single-result transaction
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_REJECT) |-> m_tlast)
    else $error("reject result not marked last");

  // More results follow, so ids must still be waiting
  a_more_queued: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[32:26] != '0))
    else $error("non-last result with empty queue");

  // Mid-burst, no new input item may be taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input accepted inside a result burst");

endmodule

bind rate_limited_query_admission_unit rlqa_checker u_rlqa_checker (.*);

// ===== test/tb_rate_limited_query_admission_unit.sv =====
module tb_rate_limited_query_admission_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rlqa_pkg::*;

  // Op codes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Two seconds in time units; the credit added by one check never covers more
  localparam logic [TIME_W-1:0] TWO_SECONDS = 32'd2 << DEF_TIME_FRAC_BITS;

  // Cycles to let pass once the last expected result is out: a check without
  // releases still walks its time and credit stages
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;

  // One input transaction, first field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic [NODES_W-1:0] nodes;
    logic [EST_W-1:0]   est;
    logic [TIME_W-1:0]  now;
    logic [ID_W-1:0]    id;
    logic [OP_W-1:0]    op;
  } query_item_t;

  // Result word on m_tdata
  typedef struct packed {
    logic [6:0]        pad;
    logic [QCNT_W-1:0] queued;
    logic [ACT_W-1:0]  active;
    logic [ID_W-1:0]   id;
  } result_word_t;

  // One predicted result
  typedef struct {
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
    logic [ACT_W-1:0]  active;
    logic [QCNT_W-1:0] queued;
    logic              last;
  } admission_t;

  // Receiver back-pressure patterns
  typedef enum logic [1:0] {FLOW_OPEN, FLOW_COIN, FLOW_SPARSE, FLOW_BEAT} flow_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // [2:0] op, [18:3] query_id, [50:19] now_time, [66:51] estimated_active,
  // [76:67] dispatch_nodes, [79:77] zero
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [15:0] query_id_res, [25:16] active_count, [32:26] queue_count, [39:33] zero
  logic [M_TDATA_W-1:0]  m_tdata;
  // [1:0] kind
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Register copies held by the predictor
  logic [RATE_W-1:0]  rate_r;
  logic [BURST_W-1:0] burst_r;
  logic [ACT_W-1:0]   min_own_r;
  logic [ACT_W-1:0]   max_own_r;
  logic [EST_W-1:0]   min_total_r;

  // Predictor state
  logic [ID_W-1:0]   queued_ids[$];
  int unsigned       own_count;
  longint unsigned   credit;
  logic [TIME_W-1:0] stamp;
  bit                abort_seen;

  // Results still owed by the block, oldest first
  admission_t pending_results[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  settings_used = 0;
  int  released_cnt = 0;
  int  aborted_cnt = 0;
  int  rejected_cnt = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  int  flow_left = 0;
  flow_t flow = FLOW_OPEN;

  rate_limited_query_admission_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("FAIL rate_limited_query_admission_unit");
      $finish;
    end
  end

  // Receiver: switch at random between back-pressure patterns
  always @(posedge clk) begin
    if (flow_left == 0) begin
      flow = flow_t'($urandom_range(0, 3));
      flow_left = $urandom_range(16, 160);
    end else begin
      flow_left--;
    end
    case (flow)
      FLOW_OPEN:   m_tready <= 1'b1;
      FLOW_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
      FLOW_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:     m_tready <= ((cycles % 5) != 0);
    endcase
  end

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("ERROR @%0d: %s", cycles, msg);
  endfunction

  function automatic void owe_result(logic [ID_W-1:0] id, logic [KIND_W-1:0] kind);
    admission_t r;
    r.id     = id;
    r.kind   = kind;
    r.active = ACT_W'(own_count);
    r.queued = QCNT_W'(queued_ids.size());
    r.last   = 1'b0;
    pending_results.push_back(r);
  endfunction

  // Token-bucket check: add credit for the elapsed time, cap it, then release
  // from the head while the own and total limits allow
  function automatic int drain_by_credit(logic [TIME_W-1:0] now, logic [EST_W-1:0] est,
                                         logic [NODES_W-1:0] nodes);
    logic [TIME_W-1:0] delay;
    longint unsigned   unit_credit;
    longint unsigned   cap_credit;
    int unsigned       floor_own;
    int unsigned       est_sum;
    logic [ID_W-1:0]   id;
    int                n;
    bit                go;
    floor_own   = abort_seen ? 0 : min_own_r;
    unit_credit = nodes;
    unit_credit = unit_credit << DEF_TIME_FRAC_BITS;
    cap_credit  = burst_r;
    cap_credit  = (cap_credit + nodes - 1) << DEF_TIME_FRAC_BITS;
    delay = '0;
    // Time running backward adds nothing and keeps the stamp
    if (now >= stamp) begin
      delay = now - stamp;
      if (delay > TWO_SECONDS) begin
        delay = TWO_SECONDS;
        // A zero stamp jumps straight to now; otherwise catch up by two seconds
        if (stamp == '0)
          stamp = now;
        else
          stamp = stamp + TWO_SECONDS;
      end else begin
        stamp = now;
      end
    end
    credit += (64'(delay) * rate_r) >> RATE_FRAC_BITS;
    if (credit >= cap_credit)
      credit = cap_credit;
    est_sum = est;
    n  = 0;
    go = 1'b1;
    while (go && (credit >= unit_credit || own_count < floor_own) && n < MAX_RESULTS) begin
      if (queued_ids.size() == 0 || own_count >= max_own_r ||
          (own_count >= floor_own && est_sum >= min_total_r)) begin
        go = 1'b0;
      end else begin
        own_count++;
        id = queued_ids.pop_front();
        est_sum += nodes;
        if (credit >= unit_credit)
          credit -= unit_credit;
        else
          credit = 0;
        owe_result(id, KIND_RELEASE);
        n++;
      end
    end
    return n;
  endfunction

  // Work out the results one accepted transaction must produce
  function automatic void predict_admission(query_item_t it);
    logic [NODES_W-1:0] nodes;
    int                 n;
    n = 0;
    nodes = (it.nodes == '0) ? NODES_W'(1) : it.nodes;
    case (it.op)
      OP_ENQUEUE: begin
        if (queued_ids.size() >= DEF_QUEUE_DEPTH) begin
          owe_result(it.id, KIND_REJECT);
          n = 1;
        end else begin
          queued_ids.push_back(it.id);
        end
      end
      OP_COMPLETE: begin
        if (own_count > 0)
          own_count--;
        n = drain_by_credit(it.now, it.est, nodes);
      end
      OP_CHECK: begin
        n = drain_by_credit(it.now, it.est, nodes);
      end
      OP_ABORT: begin
        abort_seen = 1'b1;
        while (queued_ids.size() > 0 && n < MAX_RESULTS) begin
          owe_result(queued_ids.pop_front(), KIND_ABORT);
          n++;
        end
      end
      OP_COUNT: begin
        if (own_count < ACTIVE_MAX)
          own_count++;
      end
      default: ;
    endcase
    if (n > 0)
      pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  // Compare every accepted result with the oldest one owed
  always @(posedge clk) begin : watch_results
    result_word_t got;
    admission_t   want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (m_tuser == KIND_RELEASE)
        released_cnt++;
      else if (m_tuser == KIND_ABORT)
        aborted_cnt++;
      else
        rejected_cnt++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result id=%h kind=%0d active=%0d queued=%0d last=%b",
                             got.id, m_tuser, got.active, got.queued, m_tlast));
      end else begin
        want = pending_results.pop_front();
        if (got.id !== want.id || m_tuser !== want.kind || got.active !== want.active ||
            got.queued !== want.queued || m_tlast !== want.last)
          flag_error($sformatf({"result mismatch: expected id=%h kind=%0d active=%0d ",
                                "queued=%0d last=%b, got id=%h kind=%0d active=%0d ",
                                "queued=%0d last=%b"},
                               want.id, want.kind, want.active, want.queued, want.last,
                               got.id, m_tuser, got.active, got.queued, m_tlast));
      end
    end
  end

  // Present one transaction and hold it until accepted; the sender runs in
  // bursts with random gaps in between
  task automatic send_query(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] now, input logic [EST_W-1:0] est,
                            input logic [NODES_W-1:0] nodes);
    query_item_t it;
    it.pad   = '0;
    it.op    = op;
    it.id    = id;
    it.now   = now;
    it.est   = est;
    it.nodes = nodes;
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_admission(it);
  endtask

  // Drop valid and hold until every owed result is out, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers on back-to-back cycles; call only while idle
  task automatic apply_config(input logic [RATE_W-1:0] rate, input logic [BURST_W-1:0] burst,
                              input logic [ACT_W-1:0] min_own, input logic [ACT_W-1:0] max_own,
                              input logic [EST_W-1:0] min_total);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] val[5];
    idx = '{REG_DRAIN_RATE, REG_DRAIN_BURST, REG_MIN_OWN_ACTIVE, REG_MAX_OWN_ACTIVE,
            REG_MIN_TOTAL_ACTIVE};
    val = '{CFG_DATA_W'(rate), CFG_DATA_W'(burst), CFG_DATA_W'(min_own),
            CFG_DATA_W'(max_own), CFG_DATA_W'(min_total)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    rate_r      = rate;
    burst_r     = burst;
    min_own_r   = min_own;
    max_own_r   = max_own;
    min_total_r = min_total;
    settings_used++;
  endtask

  // Mostly small rates, caps and limits so that releases stay in reach
  task automatic random_settings();
    apply_config(($urandom_range(0, 3) == 0) ? RATE_W'($urandom) :
                   RATE_W'($urandom_range(256, 10240)),
                 ($urandom_range(0, 3) == 0) ? BURST_W'($urandom) :
                   BURST_W'($urandom_range(0, 8)),
                 ACT_W'($urandom_range(0, 4)), ACT_W'($urandom_range(2, 40)),
                 EST_W'($urandom_range(0, 60)));
  endtask

  // Reset values: nothing may be released, completion at zero stays at zero,
  // a first check with a zero stamp jumps the stamp to now
  task automatic test_after_reset();
    send_query(OP_ENQUEUE, 16'h0000, '0, '0, '0);
    send_query(OP_ENQUEUE, 16'hFFFF, '1, '1, '1);
    send_query(OP_COUNT, '0, '0, '0, '0);
    send_query(OP_COMPLETE, '0, '0, '0, '0);
    send_query(OP_COMPLETE, '0, '0, '0, '0);
    send_query(OP_CHECK, '0, 32'h0010_0000, '0, '0);
    settle();
  endtask

  // Field extremes, time running backward, the two-second clamp with a live
  // stamp, large node counts and the unused op codes
  task automatic test_extremes();
    apply_config('1, '1, '0, ACTIVE_MAX, '1);
    send_query(OP_CHECK, '0, stamp + 512, '0, '0);
    repeat (3) send_query(OP_ENQUEUE, ID_W'($urandom), '0, '0, '0);
    send_query(OP_CHECK, '1, stamp - 1, '1, '1);
    send_query(OP_CHECK, '0, stamp + 3000, '0, '1);
    send_query(OP_COMPLETE, '0, stamp + 100, '0, '0);
    send_query(OP_SPARE_LO, ID_W'($urandom), TIME_W'($urandom), EST_W'($urandom), '1);
    send_query(OP_W'(OP_SPARE_LO + 1), ID_W'($urandom), TIME_W'($urandom), '0, '0);
    send_query(OP_SPARE_HI, '1, '1, '1, '1);
    settle();
  endtask

  // Own count below the minimum releases without credit, then stops
  task automatic test_min_own_release();
    apply_config('0, 16'd2, 10'd2, 10'd4, 16'd20);
    repeat (4) send_query(OP_COMPLETE, '0, stamp + 10, 16'd30, 10'd1);
    repeat (4) send_query(OP_ENQUEUE, ID_W'($urandom), '0, '0, '0);
    send_query(OP_CHECK, '0, stamp + 10, 16'd30, 10'd1);
    send_query(OP_CHECK, '0, stamp + 10, 16'd10, 10'd1);
    settle();
  endtask

  // Fill past the depth so the tail gets rejected, then abort a full queue
  task automatic test_queue_full_and_abort();
    int fill;
    apply_config('0, '0, '0, '0, '0);
    fill = DEF_QUEUE_DEPTH + 2 - queued_ids.size();
    repeat (fill) send_query(OP_ENQUEUE, ID_W'($urandom), '0, '0, '0);
    send_query(OP_ABORT, ID_W'($urandom), TIME_W'($urandom), EST_W'($urandom),
               NODES_W'($urandom));
    settle();
  endtask

  // Mostly well-formed traffic: enqueue bursts, checks and completions with time
  // moving forward from the stamp; the rest is noise on every field
  task automatic run_traffic(input int count, input bit with_abort);
    int              sent;
    int              pick;
    int              burst;
    logic [OP_W-1:0] op;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        burst = $urandom_range(1, 4);
        repeat (burst)
          send_query(OP_ENQUEUE, ID_W'($urandom), TIME_W'($urandom), EST_W'($urandom),
                     NODES_W'($urandom));
        sent += burst;
      end else if (pick < 75) begin
        op = (pick < 55) ? OP_CHECK : OP_COMPLETE;
        send_query(op, ID_W'($urandom), stamp + $urandom_range(0, 2600),
                   EST_W'($urandom_range(0, 80)), NODES_W'($urandom_range(0, 3)));
        sent++;
      end else if (pick < 83) begin
        send_query(OP_COUNT, ID_W'($urandom), TIME_W'($urandom), EST_W'($urandom),
                   NODES_W'($urandom));
        sent++;
      end else if (pick < 86 && with_abort) begin
        send_query(OP_ABORT, ID_W'($urandom), TIME_W'($urandom), EST_W'($urandom),
                   NODES_W'($urandom));
        sent++;
      end else begin
        op = OP_W'($urandom);
        if (op == OP_ABORT && !with_abort)
          op = OP_CHECK;
        send_query(op, ID_W'($urandom), TIME_W'($urandom), EST_W'($urandom),
                   NODES_W'($urandom));
        sent++;
      end
    end
    settle();
  endtask

  // Push the own count past a low hard ceiling (saturating when already near the
  // top), then free one slot
  task automatic test_active_ceiling();
    int unsigned ceiling;
    ceiling = (own_count + 3 > ACTIVE_MAX) ? ACTIVE_MAX : own_count + 3;
    apply_config('1, 16'd16, '0, ACT_W'(ceiling), '1);
    gaps_on = 1'b0;
    repeat (5) send_query(OP_COUNT, '0, '0, '0, '0);
    repeat (2) send_query(OP_ENQUEUE, ID_W'($urandom), '0, '0, '0);
    send_query(OP_CHECK, '0, stamp + 1000, '0, '0);
    send_query(OP_COMPLETE, '0, stamp + 1000, '0, '0);
    gaps_on = 1'b1;
    settle();
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rate_r      = '0;
    burst_r     = '0;
    min_own_r   = '0;
    max_own_r   = ACTIVE_MAX;
    min_total_r = '0;
    own_count   = 0;
    credit      = 0;
    stamp       = '0;
    abort_seen  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_extremes();
    test_min_own_release();

    // Random traffic before any abort, while the own minimum still counts
    random_settings();
    run_traffic(30, 1'b0);
    // Everything blocked: zero rate, zero burst, zero ceiling
    apply_config('0, '0, '0, '0, '0);
    run_traffic(10, 1'b0);
    random_settings();
    gaps_on = 1'b0;
    run_traffic(30, 1'b0);
    gaps_on = 1'b1;

    test_queue_full_and_abort();

    random_settings();
    run_traffic(35, 1'b1);
    test_active_ceiling();

    settle();
    $display("Run covered %0d input transactions over %0d register settings",
             items_sent, settings_used);
    $display("Results checked: %0d released, %0d aborted, %0d rejected; %0d mismatches",
             released_cnt, aborted_cnt, rejected_cnt, mismatches);
    if (mismatches == 0) begin
      $display("PASS rate_limited_query_admission_unit");
    end else begin
      $display("FAIL rate_limited_query_admission_unit");
    end
    $finish;
  end

endmodule
